[rtl/core/gvd_pkg.sv]
// Shared types, register map and helpers for the group varint decoder.
package gvd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PartW    = 24;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned CntW     = 2;
  localparam int unsigned GsizeW   = 3;
  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ApbAddrW-1:0] RegGroupSize   = 2'd0;
  localparam logic [GsizeW-1:0]   GroupSizeReset = 3'd4;
  localparam logic [GsizeW-1:0]   GroupSizeMin   = 3'd2;
  localparam logic [GsizeW-1:0]   GroupSizeMax   = 3'd4;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SlotW-1:0]  index;
    logic              last;
  } result_t;

  // Index of the last slot for a group size, saturated to the legal range.
  function automatic logic [SlotW-1:0] last_slot(input logic [GsizeW-1:0] gs);
    logic [GsizeW-1:0] eff;
    if (gs < GroupSizeMin) begin
      eff = GroupSizeMin;
    end else if (gs > GroupSizeMax) begin
      eff = GroupSizeMax;
    end else begin
      eff = gs;
    end
    last_slot = SlotW'(eff - 3'd1);
  endfunction

endpackage

[rtl/core/gvd_cfg.sv]
// APB register block holding the group size.
module gvd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gvd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [gvd_pkg::ApbDataW-1:0]  pwdata,
  output logic [gvd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [gvd_pkg::SlotW-1:0]     last_slot_o
);

  logic [gvd_pkg::GsizeW-1:0] gsize_q;
  logic [gvd_pkg::GsizeW-1:0] gsize_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == gvd_pkg::RegGroupSize);

  always_comb begin
    gsize_d = gsize_q;
    if (wr_en) begin
      gsize_d = pwdata[gvd_pkg::GsizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= gvd_pkg::GroupSizeReset;
    end else begin
      gsize_q <= gsize_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == gvd_pkg::RegGroupSize) begin
      prdata = {{(gvd_pkg::ApbDataW - gvd_pkg::GsizeW){1'b0}}, gsize_q};
    end
  end

  assign last_slot_o = gvd_pkg::last_slot(gsize_q);

endmodule

[rtl/core/gvd_decode.sv]
// Group parse state and per-byte value assembly.
module gvd_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [gvd_pkg::ByteW-1:0] byte_i,
  input  logic [gvd_pkg::SlotW-1:0] last_slot_i,
  output logic                      res_vld_o,
  output gvd_pkg::result_t          res_o
);

  logic                      hdr_q,   hdr_d;
  logic [gvd_pkg::ByteW-1:0] codes_q, codes_d;
  logic [gvd_pkg::SlotW-1:0] slot_q,  slot_d;
  logic [gvd_pkg::CntW-1:0]  cnt_q,   cnt_d;
  logic [gvd_pkg::PartW-1:0] part_q,  part_d;
  logic [1:0]                code;
  logic [gvd_pkg::ValueW-1:0] shifted;
  logic                      end_grp;

  assign code    = codes_q[{slot_q, 1'b0} +: 2];
  assign shifted = {{(gvd_pkg::ValueW - gvd_pkg::ByteW){1'b0}}, byte_i} << {cnt_q, 3'b000};
  assign end_grp = (slot_q >= last_slot_i);

  always_comb begin
    hdr_d     = hdr_q;
    codes_d   = codes_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    part_d    = part_q;
    res_vld_o = 1'b0;
    res_o.value = {{(gvd_pkg::ValueW - gvd_pkg::PartW){1'b0}}, part_q} | shifted;
    res_o.index = slot_q;
    res_o.last  = end_grp;
    if (fire_i) begin
      if (hdr_q) begin
        codes_d = byte_i;
        slot_d  = '0;
        cnt_d   = '0;
        part_d  = '0;
        hdr_d   = 1'b0;
      end else if (cnt_q < code) begin
        part_d = part_q | shifted[gvd_pkg::PartW-1:0];
        cnt_d  = cnt_q + 2'd1;
      end else begin
        res_vld_o = 1'b1;
        part_d    = '0;
        cnt_d     = '0;
        if (end_grp) begin
          slot_d = '0;
          hdr_d  = 1'b1;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= 1'b1;
      codes_q <= '0;
      slot_q  <= '0;
      cnt_q   <= '0;
      part_q  <= '0;
    end else begin
      hdr_q   <= hdr_d;
      codes_q <= codes_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      part_q  <= part_d;
    end
  end

`ifndef SYNTH
  a_hdr_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && hdr_q |=> !hdr_q)
    else $error("leading byte not consumed");
  a_end_to_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.last |=> hdr_q && slot_q == '0)
    else $error("group end did not return to leading byte");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_q |-> cnt_q <= code)
    else $error("byte count past value length");
  a_hdr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q |-> cnt_q == '0 && part_q == '0)
    else $error("stale partial value at leading byte");
`endif

endmodule

[rtl/core/gvd_out.sv]
// Result register toward the master stream side.
module gvd_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  gvd_pkg::result_t              res_i,
  output logic                          can_take_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [gvd_pkg::ValueW-1:0]    m_axis_tdata_o,
  output logic [gvd_pkg::SlotW-1:0]     m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic             vld_q, vld_d;
  gvd_pkg::result_t res_q, res_d;

  assign can_take_o = !vld_q || m_axis_tready_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (take_i) begin
      vld_d = 1'b1;
      res_d = res_i;
    end else if (m_axis_tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = res_q.value;
  assign m_axis_tuser_o  = res_q.index;
  assign m_axis_tlast_o  = res_q.last;

endmodule

[rtl/core/group_varint_decoder.sv]
// Group varint stream decoder top level.
// Takes one encoded byte per cycle on the slave stream unless the master stream stalls,
// and emits one decoded value on the master stream when that value's last byte has been
// consumed. A byte is registered on entry, decoded against the group state once the
// output register can take a result, and the result lands in that output register. A new
// byte can be accepted while the buffered one is decoded. Leading bytes and non-final
// value bytes produce no result. The group size register (APB offset 0) should be written
// only while the stream is idle.
module group_varint_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [gvd_pkg::ByteW-1:0]     s_axis_tdata_i,    // in_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [gvd_pkg::ValueW-1:0]    m_axis_tdata_o,    // decoded_value
  output logic [gvd_pkg::SlotW-1:0]     m_axis_tuser_o,    // value_index
  output logic                          m_axis_tlast_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gvd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [gvd_pkg::ApbDataW-1:0]  pwdata,
  output logic [gvd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  logic                      in_vld_q, in_vld_d;
  logic [gvd_pkg::ByteW-1:0] in_byte_q, in_byte_d;
  logic                      fire;
  logic                      can_take;
  logic                      res_vld;
  gvd_pkg::result_t          res;
  logic [gvd_pkg::SlotW-1:0] last_slot;
  logic                      s_acc;

  assign fire            = in_vld_q && can_take;
  assign s_axis_tready_o = !in_vld_q || fire;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (s_acc) begin
      in_vld_d  = 1'b1;
      in_byte_d = s_axis_tdata_i;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  gvd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .last_slot_o (last_slot)
  );

  gvd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .last_slot_i (last_slot),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  gvd_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (fire && res_vld),
    .res_i           (res),
    .can_take_o      (can_take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_byte_q))
    else $error("buffered byte lost");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !(fire && res_vld))
    else $error("result overwritten while stalled");
  a_fire_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> s_axis_tready_o)
    else $error("input stage blocked while draining");
`endif

endmodule

[bench/group_varint_decoder_tb.sv]
// Self-checking bench for the group varint decoder: directed byte table, then random streams.
`timescale 1ns / 100ps

module group_varint_decoder_tb;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned TargetBytes  = 1100;
  localparam int unsigned NumRows      = 26;
  localparam logic [8*gvd_pkg::GsizeW-1:0] SizeSweep =
    {3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0};

  typedef enum logic {ROW_BYTE, ROW_SIZE} row_kind_e;
  typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_TRICKLE} rx_mode_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [gvd_pkg::ByteW-1:0] data;
    logic                      typed;
    gvd_pkg::result_t          want;
  } row_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [gvd_pkg::ByteW-1:0]    s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [gvd_pkg::ValueW-1:0]   m_axis_tdata_o;
  logic [gvd_pkg::SlotW-1:0]    m_axis_tuser_o;
  logic                         m_axis_tlast_o;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [gvd_pkg::ApbAddrW-1:0] paddr           = '0;
  logic [gvd_pkg::ApbDataW-1:0] pwdata          = '0;
  logic [gvd_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  // decoder state mirror
  logic                        await_lead;
  logic [gvd_pkg::ByteW-1:0]   lead_codes;
  logic [gvd_pkg::SlotW-1:0]   cur_slot;
  logic [gvd_pkg::CntW-1:0]    bytes_taken;
  logic [gvd_pkg::PartW-1:0]   low_bytes;
  logic [gvd_pkg::GsizeW-1:0]  size_cfg;

  gvd_pkg::result_t pending_values[$];
  row_t             rows[NumRows];
  int unsigned      burst_left      = 0;
  int unsigned      bytes_fed       = 0;
  int unsigned      values_seen     = 0;
  int unsigned      group_ends_seen = 0;
  int unsigned      sizes_written   = 0;
  int unsigned      quiet_cycles    = 0;
  int unsigned      fail_count      = 0;

  group_varint_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // in_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // decoded_value
    .m_axis_tuser_o  (m_axis_tuser_o),   // value_index
    .m_axis_tlast_o  (m_axis_tlast_o),   // group_end
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic decode_byte(input logic [gvd_pkg::ByteW-1:0] b,
                                       output gvd_pkg::result_t r);
    logic [1:0]  code;
    int unsigned eff_size;
    r = '0;
    if (await_lead) begin
      lead_codes  = b;
      cur_slot    = '0;
      bytes_taken = '0;
      low_bytes   = '0;
      await_lead  = 1'b0;
      return 1'b0;
    end
    code = lead_codes[2*cur_slot +: 2];
    if (bytes_taken < code) begin
      low_bytes   = low_bytes | (gvd_pkg::PartW'(b) << (8*bytes_taken));
      bytes_taken = bytes_taken + 1'b1;
      return 1'b0;
    end
    eff_size = (size_cfg < 2) ? 2 : ((size_cfg > 4) ? 4 : size_cfg);
    r.value  = gvd_pkg::ValueW'(low_bytes) | (gvd_pkg::ValueW'(b) << (8*bytes_taken));
    r.index  = cur_slot;
    r.last   = (cur_slot >= eff_size - 1);
    low_bytes   = '0;
    bytes_taken = '0;
    if (r.last) begin
      cur_slot   = '0;
      await_lead = 1'b1;
    end else begin
      cur_slot = cur_slot + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [gvd_pkg::ByteW-1:0] stream_byte();
    case ($urandom_range(0, 7))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return gvd_pkg::ByteW'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic feed_byte(input logic [gvd_pkg::ByteW-1:0] b, input logic typed,
                           input gvd_pkg::result_t want);
    gvd_pkg::result_t predicted;
    logic             produced;
    int unsigned      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    // hold the request until taken
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_fed++;
    produced = decode_byte(b, predicted);
    if (typed) begin
      pending_values.push_back(want);
    end else if (produced) begin
      pending_values.push_back(predicted);
    end
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic is_write, input logic [gvd_pkg::ApbDataW-1:0] wdata,
                            output logic [gvd_pkg::ApbDataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= gvd_pkg::RegGroupSize;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_group_size(input logic [gvd_pkg::GsizeW-1:0] want);
    logic [gvd_pkg::ApbDataW-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback[gvd_pkg::GsizeW-1:0] !== want) begin
      $error("group_size: expected %0d, actual %0d", want, readback[gvd_pkg::GsizeW-1:0]);
      fail_count++;
    end
  endtask

  task automatic set_group_size(input logic [gvd_pkg::GsizeW-1:0] gs);
    logic [gvd_pkg::ApbDataW-1:0] unused;
    settle();
    apb_access(1'b1, gvd_pkg::ApbDataW'(gs), unused);
    check_group_size(gs);
    size_cfg = gs;
    sizes_written++;
  endtask

  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    mode      = RX_FLOW;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (mode)
        RX_FLOW: begin
          m_axis_tready_i <= 1'b1;
        end
        RX_CHOPPY: begin
          m_axis_tready_i <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          m_axis_tready_i <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  initial begin
    gvd_pkg::result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        quiet_cycles++;
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          quiet_cycles = 0;
        end
        if (m_axis_tvalid_o && m_axis_tready_i) begin
          quiet_cycles = 0;
          if (pending_values.size() == 0) begin
            $error("unexpected result: value %h index %0d last %0b",
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
            fail_count++;
          end else begin
            want = pending_values.pop_front();
            values_seen++;
            if (m_axis_tlast_o) begin
              group_ends_seen++;
            end
            if (m_axis_tdata_o !== want.value) begin
              $error("decoded_value: expected %h, actual %h", want.value, m_axis_tdata_o);
              fail_count++;
            end
            if (m_axis_tuser_o !== want.index) begin
              $error("value_index: expected %0d, actual %0d", want.index, m_axis_tuser_o);
              fail_count++;
            end
            if (m_axis_tlast_o !== want.last) begin
              $error("group_end: expected %0b, actual %0b", want.last, m_axis_tlast_o);
              fail_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    rows = '{
      {ROW_BYTE, 8'h00, 1'b0, 32'h0000_0000, 2'd0, 1'b0},  // lead: four one-byte values
      {ROW_BYTE, 8'h00, 1'b1, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hFF, 1'b1, 32'h0000_00FF, 2'd1, 1'b0},
      {ROW_BYTE, 8'h80, 1'b1, 32'h0000_0080, 2'd2, 1'b0},
      {ROW_BYTE, 8'h01, 1'b1, 32'h0000_0001, 2'd3, 1'b1},
      {ROW_BYTE, 8'hE4, 1'b0, 32'h0000_0000, 2'd0, 1'b0},  // lead: lengths 1, 2, 3, 4
      {ROW_BYTE, 8'h12, 1'b1, 32'h0000_0012, 2'd0, 1'b0},
      {ROW_BYTE, 8'h34, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'h56, 1'b1, 32'h0000_5634, 2'd1, 1'b0},
      {ROW_BYTE, 8'h01, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'h02, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'h03, 1'b1, 32'h0003_0201, 2'd2, 1'b0},
      {ROW_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 2'd3, 1'b1},
      {ROW_SIZE, 8'h00, 1'b0, 32'h0000_0000, 2'd0, 1'b0},  // saturates up to two
      {ROW_BYTE, 8'hF0, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hAA, 1'b1, 32'h0000_00AA, 2'd0, 1'b0},
      {ROW_BYTE, 8'h55, 1'b1, 32'h0000_0055, 2'd1, 1'b1},
      {ROW_SIZE, 8'h07, 1'b0, 32'h0000_0000, 2'd0, 1'b0},  // saturates down to four
      {ROW_BYTE, 8'h00, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'hC3, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_BYTE, 8'h3C, 1'b0, 32'h0000_0000, 2'd0, 1'b0},
      {ROW_SIZE, 8'h02, 1'b0, 32'h0000_0000, 2'd0, 1'b0},  // shrink inside a group
      {ROW_BYTE, 8'h77, 1'b1, 32'h0000_0077, 2'd2, 1'b1}
    };
    await_lead  = 1'b1;
    lead_codes  = '0;
    cur_slot    = '0;
    bytes_taken = '0;
    low_bytes   = '0;
    size_cfg    = gvd_pkg::GroupSizeReset;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_group_size(gvd_pkg::GroupSizeReset);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_SIZE) begin
        set_group_size(rows[i].data[gvd_pkg::GsizeW-1:0]);
      end else begin
        feed_byte(rows[i].data, rows[i].typed, rows[i].want);
      end
    end

    phase = 0;
    while (bytes_fed < TargetBytes) begin
      set_group_size(SizeSweep[gvd_pkg::GsizeW*(phase % 8) +: gvd_pkg::GsizeW]);
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) feed_byte(stream_byte(), 1'b0, '0);
      phase++;
    end
    settle();

    $display("Streamed %0d bytes across %0d group size settings, saturated ones included.",
             bytes_fed, sizes_written);
    $display("Checked %0d decoded values, %0d of them closing a group.",
             values_seen, group_ends_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
